@@ rtl/tss_pkg.sv @@
`timescale 1ns / 1ps
// tss_pkg: shared types and constants for the C subset token scanner.
// Holds the beat structs of both channels, the token codes and the group
// record passed from the scan stage to the result emitter. No dependencies.
package tss_pkg;

	localparam int IDENT_MAX_DEF = 63;
	localparam int NAME_KEEP_DEF = 31;
	localparam int LINE_BITS_DEF = 24;

	localparam int CHUNK_MAX   = 4;
	localparam int CHUNK_BYTES = 8;
	localparam int NAME_BYTES  = CHUNK_MAX * CHUNK_BYTES;
	localparam int LEN_W       = 6;
	localparam int OUT_LINE_W  = 24;

	// item kinds
	localparam logic ITEM_CHAR = 1'b0;
	localparam logic ITEM_END  = 1'b1;

	// token codes
	localparam logic [4:0] TK_END    = 5'd0;
	localparam logic [4:0] TK_INT    = 5'd1;
	localparam logic [4:0] TK_RETURN = 5'd2;
	localparam logic [4:0] TK_IF     = 5'd3;
	localparam logic [4:0] TK_ELSE   = 5'd4;
	localparam logic [4:0] TK_WHILE  = 5'd5;
	localparam logic [4:0] TK_IDENT  = 5'd6;
	localparam logic [4:0] TK_NUMBER = 5'd7;
	localparam logic [4:0] TK_LBRACE = 5'd8;
	localparam logic [4:0] TK_RBRACE = 5'd9;
	localparam logic [4:0] TK_LPAREN = 5'd10;
	localparam logic [4:0] TK_RPAREN = 5'd11;
	localparam logic [4:0] TK_SEMI   = 5'd12;
	localparam logic [4:0] TK_COMMA  = 5'd13;
	localparam logic [4:0] TK_PLUS   = 5'd14;
	localparam logic [4:0] TK_MINUS  = 5'd15;
	localparam logic [4:0] TK_STAR   = 5'd16;
	localparam logic [4:0] TK_SLASH  = 5'd17;
	localparam logic [4:0] TK_PCT    = 5'd18;
	localparam logic [4:0] TK_ASSIGN = 5'd19;
	localparam logic [4:0] TK_EQ     = 5'd20;
	localparam logic [4:0] TK_BANG   = 5'd21;
	localparam logic [4:0] TK_NE     = 5'd22;
	localparam logic [4:0] TK_LT     = 5'd23;
	localparam logic [4:0] TK_LE     = 5'd24;
	localparam logic [4:0] TK_GT     = 5'd25;
	localparam logic [4:0] TK_GE     = 5'd26;
	localparam logic [4:0] TK_AND    = 5'd27;
	localparam logic [4:0] TK_OR     = 5'd28;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_byte;
	} byte_item_t;

	typedef struct packed {
		logic [4:0]         token_kind;
		logic signed [31:0] number_value;
		logic [23:0]        token_line;
		logic [63:0]        name_chunk;
		logic [1:0]         chunk_index;
		logic [4:0]         name_length;
		logic               end_of_text;
		logic               last_of_input;
	} token_item_t;

	// up to two tokens per byte: a closed pending token, then a new one
	typedef struct packed {
		logic                    f_has;
		logic [4:0]              f_kind;
		logic [31:0]             f_value;
		logic [OUT_LINE_W-1:0]   f_line;
		logic [2:0]              f_chunks;
		logic [LEN_W-1:0]        f_len;
		logic [NAME_BYTES*8-1:0] f_name;
		logic                    s_has;
		logic [4:0]              s_kind;
		logic [OUT_LINE_W-1:0]   s_line;
		logic                    s_eot;
	} tok_group_t;

endpackage

@@ rtl/tss_scan.sv @@
`timescale 1ns / 1ps
// tss_scan: scanner state and the single-pass next-state logic for one byte.
// Builds the token group for the emitter. Depends on tss_pkg.
module tss_scan import tss_pkg::*; #(
	parameter int IDENT_MAX = IDENT_MAX_DEF,
	parameter int NAME_KEEP = NAME_KEEP_DEF,
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  byte_item_t item,
	input  logic       grp_free,
	output logic       item_done,
	output logic       grp_load,
	output tok_group_t grp
);

	localparam int CW  = $clog2(IDENT_MAX + 1);
	localparam int NI  = $clog2(NAME_KEEP);
	localparam int XW  = (CW > NI + 1) ? CW : NI + 1;
	localparam int LXW = (LINE_BITS > OUT_LINE_W) ? LINE_BITS : OUT_LINE_W;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM, M_COMMENT, M_SLASH,
		M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_BAR
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [7:0]           name_q [NAME_KEEP];
	logic [CW-1:0]        count_q, count_d;
	logic [31:0]          accum_q, accum_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [LINE_BITS-1:0] start_q, start_d;

	logic [7:0]            c;
	logic                  at_end, c_letter, c_decdig, is_blank;
	logic [3:0]            digit;
	logic [XW-1:0]         count_x, len_x;
	logic [LEN_W-1:0]      len;
	logic [6:0]            chunks_w;
	logic [2:0]            chunks;
	logic                  kw_int, kw_return, kw_if, kw_else, kw_while;
	logic [LXW-1:0]        line_ext, start_ext;
	logic [NAME_BYTES*8-1:0] name_flat;

	logic          name_we;
	logic [NI-1:0] name_wa;
	logic          consumed, is_op;
	logic [4:0]    op_single, op_pair;
	logic [7:0]    op_second;
	logic          f_has, s_has, s_eot;
	logic [4:0]    f_kind, s_kind;
	logic [31:0]   f_value;
	logic [2:0]    f_chunks;
	logic          grp_empty;

	for (genvar gi = 0; gi < NAME_BYTES; gi++) begin : g_copy
		if (gi < NAME_KEEP) begin : g_keep
			assign name_flat[gi*8 +: 8] = name_q[gi];
		end else begin : g_zero
			assign name_flat[gi*8 +: 8] = 8'h00;
		end
	end

	always_comb begin
		c        = item.char_byte;
		at_end   = (item.kind == ITEM_END) || (c == 8'h00);
		c_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
		c_decdig = c >= "0" && c <= "9";
		is_blank = c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
		digit    = 4'(c - "0");
		count_x  = XW'(count_q);
		len_x    = (count_x < XW'(NAME_KEEP)) ? count_x : XW'(NAME_KEEP);
		len      = LEN_W'(len_x);
		chunks_w = (7'(len) + 7'd7) >> 3;
		chunks   = (chunks_w > 7'd4) ? 3'd4 : chunks_w[2:0];
		line_ext  = LXW'(line_q);
		start_ext = LXW'(start_q);
		kw_int    = count_x == XW'(3) && name_q[0] == "i" && name_q[1] == "n"
			&& name_q[2] == "t";
		kw_return = count_x == XW'(6) && name_q[0] == "r" && name_q[1] == "e"
			&& name_q[2] == "t" && name_q[3] == "u" && name_q[4] == "r"
			&& name_q[5] == "n";
		kw_if     = count_x == XW'(2) && name_q[0] == "i" && name_q[1] == "f";
		kw_else   = count_x == XW'(4) && name_q[0] == "e" && name_q[1] == "l"
			&& name_q[2] == "s" && name_q[3] == "e";
		kw_while  = count_x == XW'(5) && name_q[0] == "w" && name_q[1] == "h"
			&& name_q[2] == "i" && name_q[3] == "l" && name_q[4] == "e";
	end

	always_comb begin
		mode_d    = mode_q;
		count_d   = count_q;
		accum_d   = accum_q;
		line_d    = line_q;
		start_d   = start_q;
		name_we   = 1'b0;
		name_wa   = count_x[NI-1:0];
		consumed  = 1'b0;
		is_op     = 1'b0;
		op_single = TK_END;
		op_pair   = TK_END;
		op_second = "=";
		f_has     = 1'b0;
		f_kind    = TK_END;
		f_value   = '0;
		f_chunks  = '0;
		s_has     = 1'b0;
		s_kind    = TK_END;
		s_eot     = 1'b0;

		// close the pending token
		unique case (mode_q)
			M_IDENT: begin
				if (!at_end && (c_letter || c_decdig) && count_x < XW'(IDENT_MAX)) begin
					consumed = 1'b1;
					count_d  = CW'(count_q + 1'b1);
					name_we  = count_x < XW'(NAME_KEEP);
				end else begin
					f_has = 1'b1;
					priority if (kw_int) begin
						f_kind = TK_INT;
					end else if (kw_return) begin
						f_kind = TK_RETURN;
					end else if (kw_if) begin
						f_kind = TK_IF;
					end else if (kw_else) begin
						f_kind = TK_ELSE;
					end else if (kw_while) begin
						f_kind = TK_WHILE;
					end else begin
						f_kind   = TK_IDENT;
						f_chunks = chunks;
					end
				end
			end
			M_NUM: begin
				if (!at_end && c_decdig) begin
					consumed = 1'b1;
					accum_d  = (accum_q << 3) + (accum_q << 1) + 32'(digit);
				end else begin
					f_has   = 1'b1;
					f_kind  = TK_NUMBER;
					f_value = accum_q;
				end
			end
			M_COMMENT: begin
				consumed = !at_end && c != 8'h0A;
			end
			M_SLASH: begin
				if (!at_end && c == "/") begin
					consumed = 1'b1;
					mode_d   = M_COMMENT;
				end else begin
					f_has  = 1'b1;
					f_kind = TK_SLASH;
				end
			end
			M_EQ: begin
				is_op = 1'b1; op_single = TK_ASSIGN; op_pair = TK_EQ;
			end
			M_BANG: begin
				is_op = 1'b1; op_single = TK_BANG; op_pair = TK_NE;
			end
			M_LT: begin
				is_op = 1'b1; op_single = TK_LT; op_pair = TK_LE;
			end
			M_GT: begin
				is_op = 1'b1; op_single = TK_GT; op_pair = TK_GE;
			end
			M_AMP: begin
				is_op = 1'b1; op_pair = TK_AND; op_second = "&";
			end
			M_BAR: begin
				is_op = 1'b1; op_pair = TK_OR; op_second = "|";
			end
			default: begin
			end
		endcase

		if (is_op) begin
			f_has = 1'b1;
			if (!at_end && c == op_second) begin
				consumed = 1'b1;
				f_kind   = op_pair;
				mode_d   = M_IDLE;
			end else begin
				f_kind = op_single;
			end
		end

		if (at_end) begin
			s_has   = 1'b1;
			s_kind  = TK_END;
			s_eot   = 1'b1;
			mode_d  = M_IDLE;
			count_d = '0;
			accum_d = '0;
			line_d  = LINE_BITS'(1);
			start_d = LINE_BITS'(1);
		end else if (!consumed) begin
			// scan the byte from the idle state
			mode_d = M_IDLE;
			if (is_blank) begin
				if (c == 8'h0A && !(&line_q))
					line_d = line_q + 1'b1;
			end else begin
				start_d = line_q;
				if (c_letter) begin
					mode_d  = M_IDENT;
					name_we = 1'b1;
					name_wa = '0;
					count_d = CW'(1);
				end else if (c_decdig) begin
					mode_d  = M_NUM;
					accum_d = 32'(digit);
				end else begin
					unique case (c)
						"/": mode_d = M_SLASH;
						"=": mode_d = M_EQ;
						"!": mode_d = M_BANG;
						"<": mode_d = M_LT;
						">": mode_d = M_GT;
						"&": mode_d = M_AMP;
						"|": mode_d = M_BAR;
						"{": begin s_has = 1'b1; s_kind = TK_LBRACE; end
						"}": begin s_has = 1'b1; s_kind = TK_RBRACE; end
						"(": begin s_has = 1'b1; s_kind = TK_LPAREN; end
						")": begin s_has = 1'b1; s_kind = TK_RPAREN; end
						";": begin s_has = 1'b1; s_kind = TK_SEMI; end
						",": begin s_has = 1'b1; s_kind = TK_COMMA; end
						"+": begin s_has = 1'b1; s_kind = TK_PLUS; end
						"-": begin s_has = 1'b1; s_kind = TK_MINUS; end
						"*": begin s_has = 1'b1; s_kind = TK_STAR; end
						"%": begin s_has = 1'b1; s_kind = TK_PCT; end
						default: begin s_has = 1'b1; s_kind = TK_END; end
					endcase
				end
			end
		end
	end

	always_comb begin
		grp.f_has    = f_has;
		grp.f_kind   = f_kind;
		grp.f_value  = f_value;
		grp.f_line   = start_ext[OUT_LINE_W-1:0];
		grp.f_chunks = f_chunks;
		grp.f_len    = len;
		grp.f_name   = name_flat;
		grp.s_has    = s_has;
		grp.s_kind   = s_kind;
		grp.s_line   = line_ext[OUT_LINE_W-1:0];
		grp.s_eot    = s_eot;
		grp_empty    = !f_has && !s_has;
		item_done    = item_valid && (grp_empty || grp_free);
		grp_load     = item_done && !grp_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			count_q <= '0;
			accum_q <= '0;
			line_q  <= LINE_BITS'(1);
			start_q <= LINE_BITS'(1);
		end else if (item_done) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			accum_q <= accum_d;
			line_q  <= line_d;
			start_q <= start_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_done && name_we)
			name_q[name_wa] <= c;
	end

`ifndef ASSERT_OFF
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		item_done && at_end |=> mode_q == M_IDLE && line_q == LINE_BITS'(1))
		else $error("scanner not back to idle after end of text");
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0 && start_q != '0)
		else $error("line counter reached zero");
`endif

endmodule

@@ rtl/tss_emit.sv @@
`timescale 1ns / 1ps
// tss_emit: result register holding one token group, drained one beat per cycle
// while not stalled (first token or its name chunks, then the trailing token). Depends on tss_pkg.
module tss_emit import tss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        grp_load,
	input  tok_group_t  grp,
	output logic        grp_free,
	output logic        token_valid,
	input  logic        token_stall,
	output token_item_t token_item
);

	tok_group_t  grp_q;
	logic        valid_q;
	logic [2:0]  beat_q;

	logic [2:0]  n_first, total;
	logic        last, in_first, is_chunk, take, done;
	logic [63:0] raw_chunk, chunk;
	logic [4:0]  pos;

	always_comb begin
		n_first  = !grp_q.f_has ? 3'd0 : ((grp_q.f_chunks != 3'd0) ? grp_q.f_chunks : 3'd1);
		total    = n_first + {2'b00, grp_q.s_has};
		last     = beat_q == total - 3'd1;
		in_first = beat_q < n_first;
		is_chunk = in_first && grp_q.f_chunks != 3'd0;
		raw_chunk = grp_q.f_name[{beat_q[1:0], 6'b000000} +: 64];
		chunk    = '0;
		for (int b = 0; b < CHUNK_BYTES; b++) begin
			pos = {beat_q[1:0], 3'(b)};
			if ({1'b0, pos} < grp_q.f_len)
				chunk[b*8 +: 8] = raw_chunk[b*8 +: 8];
		end
		take     = valid_q && !token_stall;
		done     = take && last;
		grp_free = !valid_q || done;

		token_valid              = valid_q;
		token_item.token_kind    = in_first ? grp_q.f_kind : grp_q.s_kind;
		token_item.number_value  = in_first ? $signed(grp_q.f_value) : 32'sd0;
		token_item.token_line    = in_first ? grp_q.f_line : grp_q.s_line;
		token_item.name_chunk    = is_chunk ? chunk : 64'd0;
		token_item.chunk_index   = is_chunk ? beat_q[1:0] : 2'd0;
		token_item.name_length   = is_chunk ? grp_q.f_len[4:0] : 5'd0;
		token_item.end_of_text   = !in_first && grp_q.s_eot;
		token_item.last_of_input = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (grp_load) begin
			valid_q <= 1'b1;
			beat_q  <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (take) begin
			beat_q <= beat_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load)
			grp_q <= grp;
	end

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		grp_load |-> grp_free)
		else $error("group loaded over an undrained group");
	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> beat_q < total)
		else $error("beat counter past end of group");
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done && !grp_load |=> !valid_q)
		else $error("result register still valid after last beat");
`endif

endmodule

@@ rtl/c_subset_token_scanner.sv @@
`timescale 1ns / 1ps
// c_subset_token_scanner: top level of the C subset token scanner.
// Input register, scan stage (tss_scan) and result emitter (tss_emit); tss_pkg.
//
// Usage:
//   byte channel (byte_valid, byte_stall, byte_item): one source byte per beat,
//   or an end-of-text beat (kind set, or a zero byte).
//   token channel (token_valid, token_stall, token_item): one token per beat;
//   identifiers take one beat per 8-byte name chunk, at most four.
//   last_of_input marks the final beat caused by a source byte.
// Path: a byte is held in the input register, scanned by tss_scan, and its
//   first result beat is presented from the result register in tss_emit.
// Throughput: one byte per cycle while each byte causes at most one token and
//   token_stall is low. A byte that causes k token beats holds the result register
//   until all k are taken (k up to 5: four name chunks plus a punctuation or end
//   token); bytes that cause nothing pass even while the result register is busy.
// Stall: while token_stall is high the current token beat holds; the input
//   register holds one byte more, then byte_stall rises.
// Reset: arst_n clears scanner state; line count restarts at 1, nothing
//   valid on either side. An end-of-text beat also returns the scanner to
//   this state after flushing the pending token.
module c_subset_token_scanner import tss_pkg::*; #(
	parameter int IDENT_MAX = IDENT_MAX_DEF,
	parameter int NAME_KEEP = NAME_KEEP_DEF,
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  byte_item_t  byte_item,
	output logic        token_valid,
	input  logic        token_stall,
	output token_item_t token_item
);

	byte_item_t item_s1;
	logic       valid_s1;
	logic       item_done, grp_load, grp_free, accept;
	tok_group_t grp;

	assign byte_stall = valid_s1 && !item_done;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= byte_item;
	end

	tss_scan #(
		.IDENT_MAX (IDENT_MAX),
		.NAME_KEEP (NAME_KEEP),
		.LINE_BITS (LINE_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.grp_free   (grp_free),
		.item_done  (item_done),
		.grp_load   (grp_load),
		.grp        (grp)
	);

	tss_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.grp_load    (grp_load),
		.grp         (grp),
		.grp_free    (grp_free),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for c_subset_token_scanner, driven first by a directed table and then
// by random C-like source text. Tokens are checked against a bench scanner model or typed rows.
// Depends on tss_pkg and the c_subset_token_scanner top level.
module tb;
	import tss_pkg::*;

	localparam int          IDENT_LIMIT  = IDENT_MAX_DEF;
	localparam int          KEEP         = NAME_KEEP_DEF;
	localparam logic [23:0] LINE_TOP     = 24'hFFFFFF;
	localparam int          CYCLE_LIMIT  = 100000;
	localparam int          RANDOM_ITEMS = 96;
	localparam int          DRAIN_CYCLES = 10;
	localparam logic [7:0]  CH_TAB       = 8'h09;
	localparam logic [7:0]  CH_LF        = 8'h0A;
	localparam logic [7:0]  CH_CR        = 8'h0D;
	localparam logic [7:0]  CH_NUL       = 8'h00;

	typedef enum logic [3:0] {
		SC_IDLE, SC_IDENT, SC_NUM, SC_COMMENT, SC_SLASH,
		SC_EQ, SC_BANG, SC_LT, SC_GT, SC_AMP, SC_BAR
	} scan_mode_e;

	typedef struct packed {
		byte_item_t  beat;
		logic        typed;
		token_item_t want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	byte_item_t  byte_item;
	logic        token_valid;
	logic        token_stall;
	token_item_t token_item;

	scan_mode_e  mode;
	logic [7:0]  name_q [KEEP];
	int unsigned ident_cnt;
	logic [31:0] num_acc;
	logic [23:0] line_no;
	logic [23:0] first_ln;

	token_item_t step_tokens[$];
	token_item_t pending_tokens[$];
	plan_row_t   plan[$];
	byte_item_t  text[$];
	int          errors = 0;
	int          cycles = 0;
	int          stall_left = 0;
	int          seen = 0;
	int          fed = 0;

	string keyword_text [5] = '{"int", "return", "if", "else", "while"};
	string pair_text [6] = '{"==", "!=", "<=", ">=", "&&", "||"};
	string single_text = "{}();,+-*/%=!<>&|";
	string name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	c_subset_token_scanner DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_item (token_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// scanner model
	function automatic void emit(logic [4:0] k, logic [31:0] v, logic [23:0] ln,
			logic [63:0] chunk, logic [1:0] idx, logic [4:0] len, logic eot);
		token_item_t t;
		t.token_kind    = k;
		t.number_value  = v;
		t.token_line    = ln;
		t.name_chunk    = chunk;
		t.chunk_index   = idx;
		t.name_length   = len;
		t.end_of_text   = eot;
		t.last_of_input = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic bit letter_byte(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit digit_byte(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void reset_scanner();
		mode      = SC_IDLE;
		ident_cnt = 0;
		num_acc   = '0;
		line_no   = 24'd1;
		first_ln  = 24'd1;
		foreach (name_q[i]) name_q[i] = '0;
	endfunction

	function automatic logic [4:0] keyword_of();
		logic [47:0] word;
		word = '0;
		if (ident_cnt > 6) return TK_IDENT;
		for (int i = 0; i < ident_cnt; i++) word = {word[39:0], name_q[i]};
		case (word)
		"int":    return TK_INT;
		"return": return TK_RETURN;
		"if":     return TK_IF;
		"else":   return TK_ELSE;
		"while":  return TK_WHILE;
		default:  return TK_IDENT;
		endcase
	endfunction

	function automatic void flush_ident();
		int unsigned len;
		int unsigned chunks;
		logic [4:0]  kw;
		logic [63:0] w;
		len = ident_cnt < KEEP ? ident_cnt : KEEP;
		kw = keyword_of();
		if (kw != TK_IDENT) begin
			emit(kw, '0, first_ln, '0, '0, '0, 1'b0);
			return;
		end
		chunks = (len + 7) / 8;
		if (chunks > 4) chunks = 4;
		for (int i = 0; i < chunks; i++) begin
			w = '0;
			for (int b = 0; b < 8; b++)
				if (i * 8 + b < len) w[8 * b +: 8] = name_q[i * 8 + b];
			emit(TK_IDENT, '0, first_ln, w, 2'(i), 5'(len), 1'b0);
		end
	endfunction

	// closes the pending token; 1 when the byte was taken by it
	function automatic bit close_pending(logic [7:0] c, bit at_end);
		logic [4:0] single;
		logic [4:0] pair;
		logic [7:0] second;
		single = TK_END;
		pair   = TK_END;
		second = "=";
		case (mode)
		SC_IDENT: begin
			if (!at_end && (letter_byte(c) || digit_byte(c)) && ident_cnt < IDENT_LIMIT) begin
				if (ident_cnt < KEEP) name_q[ident_cnt] = c;
				ident_cnt++;
				return 1'b1;
			end
			flush_ident();
			return 1'b0;
		end
		SC_NUM: begin
			if (!at_end && digit_byte(c)) begin
				num_acc = num_acc * 32'd10 + ({24'b0, c} - 32'd48);
				return 1'b1;
			end
			emit(TK_NUMBER, num_acc, first_ln, '0, '0, '0, 1'b0);
			return 1'b0;
		end
		SC_COMMENT: return !(at_end || c == CH_LF);
		SC_SLASH: begin
			if (!at_end && c == "/") begin
				mode = SC_COMMENT;
				return 1'b1;
			end
			emit(TK_SLASH, '0, first_ln, '0, '0, '0, 1'b0);
			return 1'b0;
		end
		SC_EQ: begin single = TK_ASSIGN; pair = TK_EQ; end
		SC_BANG: begin single = TK_BANG; pair = TK_NE; end
		SC_LT: begin single = TK_LT; pair = TK_LE; end
		SC_GT: begin single = TK_GT; pair = TK_GE; end
		SC_AMP: begin single = TK_END; pair = TK_AND; second = "&"; end
		SC_BAR: begin single = TK_END; pair = TK_OR; second = "|"; end
		default: return 1'b0;
		endcase
		if (!at_end && c == second) begin
			emit(pair, '0, first_ln, '0, '0, '0, 1'b0);
			mode = SC_IDLE;
			return 1'b1;
		end
		emit(single, '0, first_ln, '0, '0, '0, 1'b0);
		return 1'b0;
	endfunction

	function automatic void scan_idle(logic [7:0] c);
		logic [4:0] k;
		mode = SC_IDLE;
		if (c == " " || c == CH_TAB || c == CH_CR || c == CH_LF) begin
			if (c == CH_LF && line_no < LINE_TOP) line_no++;
			return;
		end
		first_ln = line_no;
		if (letter_byte(c)) begin
			mode      = SC_IDENT;
			name_q[0] = c;
			ident_cnt = 1;
			return;
		end
		if (digit_byte(c)) begin
			mode    = SC_NUM;
			num_acc = {24'b0, c} - 32'd48;
			return;
		end
		case (c)
		"/": begin mode = SC_SLASH; return; end
		"=": begin mode = SC_EQ; return; end
		"!": begin mode = SC_BANG; return; end
		"<": begin mode = SC_LT; return; end
		">": begin mode = SC_GT; return; end
		"&": begin mode = SC_AMP; return; end
		"|": begin mode = SC_BAR; return; end
		"{": k = TK_LBRACE;
		"}": k = TK_RBRACE;
		"(": k = TK_LPAREN;
		")": k = TK_RPAREN;
		";": k = TK_SEMI;
		",": k = TK_COMMA;
		"+": k = TK_PLUS;
		"-": k = TK_MINUS;
		"*": k = TK_STAR;
		"%": k = TK_PCT;
		default: k = TK_END;
		endcase
		emit(k, '0, line_no, '0, '0, '0, 1'b0);
	endfunction

	function automatic void scan_byte(byte_item_t b);
		bit          at_end;
		token_item_t t;
		step_tokens.delete();
		at_end = (b.kind == ITEM_END) || (b.char_byte == CH_NUL);
		if (at_end) begin
			void'(close_pending(CH_NUL, 1'b1));
			emit(TK_END, '0, line_no, '0, '0, '0, 1'b1);
			reset_scanner();
		end else if (!close_pending(b.char_byte, 1'b0)) begin
			scan_idle(b.char_byte);
		end
		if (step_tokens.size() > 0) begin
			t = step_tokens.pop_back();
			t.last_of_input = 1'b1;
			step_tokens.push_back(t);
		end
	endfunction

	// stimulus
	function automatic void add_row(logic kind, logic [7:0] ch, logic typed = 1'b0,
			logic [4:0] tk = TK_END, logic [23:0] ln = 24'd1, logic eot = 1'b0);
		plan_row_t r;
		r.beat.kind      = kind;
		r.beat.char_byte = ch;
		r.typed          = typed;
		r.want           = '0;
		r.want.token_kind    = tk;
		r.want.token_line    = ln;
		r.want.end_of_text   = eot;
		r.want.last_of_input = 1'b1;
		plan.push_back(r);
	endfunction

	function automatic void put_char(logic kind, logic [7:0] ch);
		byte_item_t b;
		b.kind      = kind;
		b.char_byte = ch;
		text.push_back(b);
	endfunction

	function automatic logic [7:0] name_char(bit first);
		return name_chars[first ? $urandom_range(0, 52) : $urandom_range(0, 62)];
	endfunction

	function automatic void build_text();
		int          long_at;
		int unsigned n;
		logic [7:0]  c;
		string       s;
		long_at = $urandom_range(0, 8);
		for (int seg = 0; text.size() < RANDOM_ITEMS; seg++) begin
			if (seg == long_at) begin
				// identifier run past its length limit
				put_char(ITEM_CHAR, name_char(1'b1));
				for (int i = 1; i < IDENT_LIMIT; i++) put_char(ITEM_CHAR, name_char(1'b0));
				put_char(ITEM_CHAR, "5");
				put_char(ITEM_CHAR, name_char(1'b0));
			end else begin
				case ($urandom_range(0, 11))
				0: begin
					s = keyword_text[$urandom_range(0, 4)];
					for (int i = 0; i < s.len(); i++) put_char(ITEM_CHAR, s[i]);
				end
				1, 2: begin
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
					put_char(ITEM_CHAR, name_char(1'b1));
					for (int i = 1; i < n; i++) put_char(ITEM_CHAR, name_char(1'b0));
				end
				3: begin
					n = $urandom_range(1, 12);
					for (int i = 0; i < n; i++) put_char(ITEM_CHAR, 8'("0" + $urandom_range(0, 9)));
				end
				4: begin
					s = pair_text[$urandom_range(0, 5)];
					for (int i = 0; i < s.len(); i++) put_char(ITEM_CHAR, s[i]);
				end
				5: put_char(ITEM_CHAR, single_text[$urandom_range(0, single_text.len() - 1)]);
				6: begin
					put_char(ITEM_CHAR, "/");
					put_char(ITEM_CHAR, "/");
					n = $urandom_range(0, 6);
					for (int i = 0; i < n; i++) begin
						c = 8'($urandom_range(1, 255));
						put_char(ITEM_CHAR, c == CH_LF ? "c" : c);
					end
					if ($urandom_range(0, 3) == 0) put_char(ITEM_END, 8'($urandom_range(0, 255)));
					else put_char(ITEM_CHAR, CH_LF);
				end
				7: put_char(ITEM_CHAR, ($urandom_range(0, 1) == 0) ? CH_LF : " ");
				8: put_char(ITEM_CHAR, 8'($urandom_range(0, 255)));
				9: begin
					if ($urandom_range(0, 2) == 0) put_char(ITEM_CHAR, "/");
					if ($urandom_range(0, 1) == 0) put_char(ITEM_END, 8'($urandom_range(0, 255)));
					else put_char(ITEM_CHAR, CH_NUL);
				end
				default: ;
				endcase
			end
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 5))
				0: put_char(ITEM_CHAR, CH_TAB);
				1: put_char(ITEM_CHAR, CH_CR);
				2: put_char(ITEM_CHAR, CH_LF);
				default: put_char(ITEM_CHAR, " ");
				endcase
			end
		end
		put_char(ITEM_END, 8'hFF);
	endfunction

	task automatic feed(plan_row_t r);
		int gap;
		gap = ((fed % 40) >= 30) ? 0 : $urandom_range(0, 4);
		fed++;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= r.beat;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		scan_byte(r.beat);
		if (r.typed) pending_tokens.push_back(r.want);
		else foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
		@(negedge clk);
	endtask

	// result side
	initial begin
		token_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				token_stall <= 1'b1;
				stall_left--;
			end else begin
				token_stall <= 1'b0;
			end
		end
	end

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		token_item_t want;
		if (arst_n && token_valid && !token_stall) begin
			seen++;
			stall_left = ((seen % 30) >= 20) ? 0 : $urandom_range(0, 4);
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected token expected none got kind %0d line %0d", $time,
					token_item.token_kind, token_item.token_line);
				errors++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("token_kind", want.token_kind, token_item.token_kind);
				check_field("number_value", want.number_value, token_item.number_value);
				check_field("token_line", want.token_line, token_item.token_line);
				check_field("name_chunk", want.name_chunk, token_item.name_chunk);
				check_field("chunk_index", want.chunk_index, token_item.chunk_index);
				check_field("name_length", want.name_length, token_item.name_length);
				check_field("end_of_text", want.end_of_text, token_item.end_of_text);
				check_field("last_of_input", want.last_of_input, token_item.last_of_input);
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_item  = '0;
		reset_scanner();

		add_row(ITEM_CHAR, "@", 1'b1, TK_END, 24'd1);
		add_row(ITEM_CHAR, 8'hFF, 1'b1, TK_END, 24'd1);
		add_row(ITEM_CHAR, "{", 1'b1, TK_LBRACE, 24'd1);
		add_row(ITEM_CHAR, "i");
		add_row(ITEM_CHAR, "f");
		add_row(ITEM_CHAR, "(");
		add_row(ITEM_CHAR, "7");
		add_row(ITEM_CHAR, ")");
		add_row(ITEM_CHAR, CH_LF);
		add_row(ITEM_CHAR, "&");
		add_row(ITEM_CHAR, " ", 1'b1, TK_END, 24'd2);
		add_row(ITEM_CHAR, "|");
		add_row(ITEM_CHAR, "|", 1'b1, TK_OR, 24'd2);
		add_row(ITEM_CHAR, "/");
		add_row(ITEM_CHAR, "/");
		add_row(ITEM_CHAR, 8'h80);
		add_row(ITEM_CHAR, CH_LF);
		add_row(ITEM_CHAR, "/");
		add_row(ITEM_CHAR, "=");
		add_row(ITEM_CHAR, "=", 1'b1, TK_EQ, 24'd3);
		add_row(ITEM_CHAR, "x");
		add_row(ITEM_END, "q");
		add_row(ITEM_CHAR, CH_NUL, 1'b1, TK_END, 24'd1, 1'b1);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) feed(plan[i]);
		build_text();
		foreach (text[i]) feed('{beat: text[i], typed: 1'b0, want: '0});
		byte_valid <= 1'b0;

		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tss_pkg.sv
rtl/tss_scan.sv
rtl/tss_emit.sv
rtl/c_subset_token_scanner.sv
tb/tb.sv
